[design/assert_macros.svh]
// Assertion helpers for the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check an implication that must hold in the next cycle
`define ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

[design/fvn_pkg.sv]
package fvn_pkg;

  localparam int TABLE_SIZE = 256;
  localparam int OCT_W      = 5;
  localparam int CFG_W      = 24;
  localparam int IDX_W      = 2;

  localparam logic [IDX_W-1:0] CFG_FREQUENCY = 2'd0;
  localparam logic [IDX_W-1:0] CFG_OCTAVES   = 2'd1;
  localparam logic [IDX_W-1:0] CFG_SEED      = 2'd2;

  localparam logic [23:0] FREQUENCY_RESET = 24'd65536;
  localparam logic [3:0]  OCTAVES_RESET   = 4'd4;
  localparam logic [7:0]  SEED_RESET      = 8'd0;

  typedef struct packed {
    logic             en;
    logic [7:0]       seed;
    logic [OCT_W-1:0] octave_count;
  } fvn_ctrl_t;

  localparam logic [7:0] PERM [TABLE_SIZE] = '{
    8'd208, 8'd34, 8'd231, 8'd213, 8'd32, 8'd248, 8'd233, 8'd56, 8'd161, 8'd78,
    8'd24, 8'd140, 8'd71, 8'd48, 8'd140, 8'd254, 8'd245, 8'd255, 8'd247, 8'd247,
    8'd40, 8'd185, 8'd248, 8'd251, 8'd245, 8'd28, 8'd124, 8'd204, 8'd204, 8'd76,
    8'd36, 8'd1, 8'd107, 8'd28, 8'd234, 8'd163, 8'd202, 8'd224, 8'd245, 8'd128,
    8'd167, 8'd204, 8'd9, 8'd92, 8'd217, 8'd54, 8'd239, 8'd174, 8'd173, 8'd102,
    8'd193, 8'd189, 8'd190, 8'd121, 8'd100, 8'd108, 8'd167, 8'd44, 8'd43, 8'd77,
    8'd180, 8'd204, 8'd8, 8'd81, 8'd70, 8'd223, 8'd11, 8'd38, 8'd24, 8'd254,
    8'd210, 8'd210, 8'd177, 8'd32, 8'd81, 8'd195, 8'd243, 8'd125, 8'd8, 8'd169,
    8'd112, 8'd32, 8'd97, 8'd53, 8'd195, 8'd13, 8'd203, 8'd9, 8'd47, 8'd104,
    8'd125, 8'd117, 8'd114, 8'd124, 8'd165, 8'd203, 8'd181, 8'd235, 8'd193, 8'd206,
    8'd70, 8'd180, 8'd174, 8'd0, 8'd167, 8'd181, 8'd41, 8'd164, 8'd30, 8'd116,
    8'd127, 8'd198, 8'd245, 8'd146, 8'd87, 8'd224, 8'd149, 8'd206, 8'd57, 8'd4,
    8'd192, 8'd210, 8'd65, 8'd210, 8'd129, 8'd240, 8'd178, 8'd105, 8'd228, 8'd108,
    8'd245, 8'd148, 8'd140, 8'd40, 8'd35, 8'd195, 8'd38, 8'd58, 8'd65, 8'd207,
    8'd215, 8'd253, 8'd65, 8'd85, 8'd208, 8'd76, 8'd62, 8'd3, 8'd237, 8'd55,
    8'd89, 8'd232, 8'd50, 8'd217, 8'd64, 8'd244, 8'd157, 8'd199, 8'd121, 8'd252,
    8'd90, 8'd17, 8'd212, 8'd203, 8'd149, 8'd152, 8'd140, 8'd187, 8'd234, 8'd177,
    8'd73, 8'd174, 8'd193, 8'd100, 8'd192, 8'd143, 8'd97, 8'd53, 8'd145, 8'd135,
    8'd19, 8'd103, 8'd13, 8'd90, 8'd135, 8'd151, 8'd199, 8'd91, 8'd239, 8'd247,
    8'd33, 8'd39, 8'd145, 8'd101, 8'd120, 8'd99, 8'd3, 8'd186, 8'd86, 8'd99,
    8'd41, 8'd237, 8'd203, 8'd111, 8'd79, 8'd220, 8'd135, 8'd158, 8'd42, 8'd30,
    8'd154, 8'd120, 8'd67, 8'd87, 8'd167, 8'd135, 8'd176, 8'd183, 8'd191, 8'd253,
    8'd115, 8'd184, 8'd21, 8'd233, 8'd58, 8'd129, 8'd233, 8'd142, 8'd39, 8'd128,
    8'd211, 8'd118, 8'd137, 8'd139, 8'd255, 8'd114, 8'd20, 8'd218, 8'd113, 8'd154,
    8'd27, 8'd127, 8'd246, 8'd250, 8'd1, 8'd8, 8'd198, 8'd250, 8'd209, 8'd92,
    8'd222, 8'd173, 8'd21, 8'd88, 8'd102, 8'd219
  };

endpackage

[design/fvn_coord_if.sv]
interface fvn_coord_if;
  logic        valid;
  logic        ready;
  logic [31:0] x_coord;
  logic [31:0] y_coord;

  modport source (output valid, output x_coord, output y_coord, input ready);
  modport sink (input valid, input x_coord, input y_coord, output ready);
endinterface

[design/fvn_noise_if.sv]
interface fvn_noise_if;
  logic        valid;
  logic        ready;
  logic [15:0] noise_value;

  modport source (output valid, output noise_value, input ready);
  modport sink (input valid, input noise_value, output ready);
endinterface

[design/fvn_octave_cell.sv]
module fvn_octave_cell
  import fvn_pkg::*;
#(
  parameter int FRAC_BITS   = 16,
  parameter int MAX_OCTAVES = 8,
  parameter int OCTAVE      = 0
) (
  input  logic                            clk,
  input  logic                            rst,
  input  fvn_ctrl_t                       ctrl,
  input  logic                            in_valid,
  input  logic [8+FRAC_BITS-1:0]          in_x,
  input  logic [8+FRAC_BITS-1:0]          in_y,
  input  logic [8+FRAC_BITS+MAX_OCTAVES-1:0] in_acc,
  output logic                            out_valid,
  output logic [8+FRAC_BITS-1:0]          out_x,
  output logic [8+FRAC_BITS-1:0]          out_y,
  output logic [8+FRAC_BITS+MAX_OCTAVES-1:0] out_acc
);

  localparam int F  = FRAC_BITS;
  localparam int CW = 8 + F;
  localparam int AW = 8 + F + MAX_OCTAVES;
  localparam logic [F+1:0] THREE_ONE = (F+2)'(3) << F;

  // stage 1: squares and row hashes
  logic          v1;
  logic [CW-1:0] x1, y1;
  logic [AW-1:0] acc1;
  logic [2*F-1:0] sqx1, sqy1;
  logic [7:0]    r0_1, r1_1;
  logic [7:0]    row0, row1;

  // stage 2: weights and corners
  logic          v2;
  logic [CW-1:0] x2, y2;
  logic [AW-1:0] acc2;
  logic [F:0]    wx2, wy2;
  logic [7:0]    c00, c10, c01, c11;
  logic [F+1:0]  kx, ky;
  logic [2*F+1:0] px, py;
  logic [7:0]    col0, col1;

  // stage 3: blend along x
  logic          v3;
  logic [CW-1:0] x3, y3;
  logic [AW-1:0] acc3;
  logic [F:0]    wy3;
  logic [CW-1:0] lo3, hi3;
  logic [CW-1:0] lo_next, hi_next;
  logic [7:0]    mag_lo, mag_hi;
  logic [F+8:0]  prod_lo, prod_hi;

  // stage 4: blend along y
  logic          v4;
  logic [CW-1:0] x4, y4;
  logic [AW-1:0] acc4;
  logic [CW-1:0] noise4;
  logic [CW-1:0] noise_next;
  logic [CW-1:0] mag_y;
  logic [CW+F:0] prod_y;

  logic active;

  assign row0 = in_y[CW-1:F] + ctrl.seed;
  assign row1 = row0 + 8'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ctrl.en) begin
      v1 <= in_valid;
    end
    if (ctrl.en) begin
      x1   <= in_x;
      y1   <= in_y;
      acc1 <= in_acc;
      sqx1 <= (2*F)'(in_x[F-1:0]) * (2*F)'(in_x[F-1:0]);
      sqy1 <= (2*F)'(in_y[F-1:0]) * (2*F)'(in_y[F-1:0]);
      r0_1 <= PERM[row0];
      r1_1 <= PERM[row1];
    end
  end

  assign col0 = x1[CW-1:F];
  assign col1 = col0 + 8'd1;
  assign kx   = THREE_ONE - {1'b0, x1[F-1:0], 1'b0};
  assign ky   = THREE_ONE - {1'b0, y1[F-1:0], 1'b0};
  assign px   = (2*F+2)'(sqx1[2*F-1:F]) * (2*F+2)'(kx);
  assign py   = (2*F+2)'(sqy1[2*F-1:F]) * (2*F+2)'(ky);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ctrl.en) begin
      v2 <= v1;
    end
    if (ctrl.en) begin
      x2   <= x1;
      y2   <= y1;
      acc2 <= acc1;
      wx2  <= px[2*F:F];
      wy2  <= py[2*F:F];
      c00  <= PERM[8'(r0_1 + col0)];
      c10  <= PERM[8'(r0_1 + col1)];
      c01  <= PERM[8'(r1_1 + col0)];
      c11  <= PERM[8'(r1_1 + col1)];
    end
  end

  // integer corner step times a Q0.F weight is already Q8.F
  always_comb begin
    mag_lo  = (c10 >= c00) ? (c10 - c00) : (c00 - c10);
    mag_hi  = (c11 >= c01) ? (c11 - c01) : (c01 - c11);
    prod_lo = (F+9)'(mag_lo) * (F+9)'(wx2);
    prod_hi = (F+9)'(mag_hi) * (F+9)'(wx2);
    if (c10 >= c00) begin
      lo_next = {c00, {F{1'b0}}} + CW'(prod_lo);
    end else begin
      lo_next = {c00, {F{1'b0}}} - CW'(prod_lo);
    end
    if (c11 >= c01) begin
      hi_next = {c01, {F{1'b0}}} + CW'(prod_hi);
    end else begin
      hi_next = {c01, {F{1'b0}}} - CW'(prod_hi);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (ctrl.en) begin
      v3 <= v2;
    end
    if (ctrl.en) begin
      x3   <= x2;
      y3   <= y2;
      acc3 <= acc2;
      wy3  <= wy2;
      lo3  <= lo_next;
      hi3  <= hi_next;
    end
  end

  always_comb begin
    mag_y  = (hi3 >= lo3) ? (hi3 - lo3) : (lo3 - hi3);
    prod_y = (CW+F+1)'(mag_y) * (CW+F+1)'(wy3);
    if (hi3 >= lo3) begin
      noise_next = lo3 + prod_y[CW+F-1:F];
    end else begin
      noise_next = lo3 - prod_y[CW+F-1:F];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (ctrl.en) begin
      v4 <= v3;
    end
    if (ctrl.en) begin
      x4     <= x3;
      y4     <= y3;
      acc4   <= acc3;
      noise4 <= noise_next;
    end
  end

  // octaves past the configured count leave the sum untouched
  assign active = OCT_W'(OCTAVE) < ctrl.octave_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.en) begin
      out_valid <= v4;
    end
    if (ctrl.en) begin
      out_x   <= {x4[CW-2:0], 1'b0};
      out_y   <= {y4[CW-2:0], 1'b0};
      out_acc <= active ? ({acc4[AW-2:0], 1'b0} + AW'(noise4)) : acc4;
    end
  end

endmodule

[design/fvn_div_cell.sv]
module fvn_div_cell
  import fvn_pkg::*;
#(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  fvn_ctrl_t     ctrl,
  input  logic [DW-1:0] div,
  input  logic          in_valid,
  input  logic [DW-1:0] in_rem,
  input  logic [15:0]   in_low,
  input  logic [15:0]   in_q,
  output logic          out_valid,
  output logic [DW-1:0] out_rem,
  output logic [15:0]   out_low,
  output logic [15:0]   out_q
);

  logic [DW:0] trial;
  logic [DW:0] diff;
  logic        qbit;

  // bring down the next dividend bit and try one subtraction
  assign trial = {in_rem, in_low[15]};
  assign diff  = trial - {1'b0, div};
  assign qbit  = trial >= {1'b0, div};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.en) begin
      out_valid <= in_valid;
    end
    if (ctrl.en) begin
      out_rem <= qbit ? diff[DW-1:0] : trial[DW-1:0];
      out_low <= {in_low[14:0], 1'b0};
      out_q   <= {in_q[14:0], qbit};
    end
  end

endmodule

[design/fractal_value_noise_2d_unit.sv]
// Channel | Role   | Payload
// coord   | sink   | x_coord[31:0], y_coord[31:0]  (unsigned Q16.16)
// noise   | source | noise_value[15:0]             (unsigned Q0.16)
// cfg     | write  | cfg_we, cfg_index[1:0], cfg_data[23:0]
//
// One request is taken every cycle while the skid register is empty.
// A request passes the input scaling register, the chain of octave cells
// (five stages each), the sixteen-stage restoring divider and the output register.
// Reset clears all valid bits and loads the register defaults.
// A skid register behind the output parks one more result while a result
// waits; the whole pipeline holds only when the skid register is full.
module fractal_value_noise_2d_unit
  import fvn_pkg::*;
#(
  parameter int MAX_OCTAVES = 8,
  parameter int FRAC_BITS   = 16
) (
  input  logic              clk,
  input  logic              rst,
  fvn_coord_if.sink         coord,
  fvn_noise_if.source       noise,
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

`include "assert_macros.svh"

  localparam int F  = FRAC_BITS;
  localparam int CW = 8 + F;
  localparam int AW = 8 + F + MAX_OCTAVES;
  localparam int N  = MAX_OCTAVES;
  localparam int QB = 16;

  logic [23:0] frequency;
  logic [3:0]  octaves;
  logic [7:0]  seed;

  logic [OCT_W-1:0] n_oct;
  logic [N-1:0]     divisor;
  fvn_ctrl_t        ctrl;
  logic             en;

  logic        fv;
  logic [55:0] fx, fy;

  logic          cv [N+1];
  logic [CW-1:0] cx [N+1];
  logic [CW-1:0] cy [N+1];
  logic [AW-1:0] ca [N+1];

  logic          dv [QB+1];
  logic [N-1:0]  dr [QB+1];
  logic [15:0]   dl [QB+1];
  logic [15:0]   dq [QB+1];

  logic        skv;
  logic [15:0] skq;

  always_ff @(posedge clk) begin
    if (rst) begin
      frequency <= FREQUENCY_RESET;
      octaves   <= OCTAVES_RESET;
      seed      <= SEED_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FREQUENCY: frequency <= cfg_data[23:0];
        CFG_OCTAVES:   octaves   <= cfg_data[3:0];
        CFG_SEED:      seed      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (octaves == 4'd0) begin
      n_oct = OCT_W'(1);
    end else if ({1'b0, octaves} > OCT_W'(N)) begin
      n_oct = OCT_W'(N);
    end else begin
      n_oct = {1'b0, octaves};
    end
    // 2^n - 1 as a mask of n ones
    for (int k = 0; k < N; k++) begin
      divisor[k] = OCT_W'(k) < n_oct;
    end
  end

  assign en               = !skv;
  assign coord.ready      = en;
  assign ctrl.en          = en;
  assign ctrl.seed        = seed;
  assign ctrl.octave_count = n_oct;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (en) begin
      fv <= coord.valid;
    end
    if (en) begin
      fx <= 56'(coord.x_coord) * 56'(frequency);
      fy <= 56'(coord.y_coord) * 56'(frequency);
    end
  end

  // keep the scaled coordinate modulo 256 in the integer part
  assign cv[0] = fv;
  assign cx[0] = fx[32-F +: CW];
  assign cy[0] = fy[32-F +: CW];
  assign ca[0] = '0;

  for (genvar i = 0; i < N; i++) begin : g_oct
    fvn_octave_cell #(
      .FRAC_BITS  (F),
      .MAX_OCTAVES(N),
      .OCTAVE     (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .in_valid (cv[i]),
      .in_x     (cx[i]),
      .in_y     (cy[i]),
      .in_acc   (ca[i]),
      .out_valid(cv[i+1]),
      .out_x    (cx[i+1]),
      .out_y    (cy[i+1]),
      .out_acc  (ca[i+1])
    );
  end

  // divide sum / 2^(F-8) by 2^n - 1; the quotient always fits 16 bits
  assign dv[0] = cv[N];
  assign dr[0] = ca[N][F+8 +: N];
  assign dl[0] = ca[N][F-8 +: 16];
  assign dq[0] = '0;

  for (genvar j = 0; j < QB; j++) begin : g_div
    fvn_div_cell #(
      .DW(N)
    ) u_div (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .div      (divisor),
      .in_valid (dv[j]),
      .in_rem   (dr[j]),
      .in_low   (dl[j]),
      .in_q     (dq[j]),
      .out_valid(dv[j+1]),
      .out_rem  (dr[j+1]),
      .out_low  (dl[j+1]),
      .out_q    (dq[j+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      noise.valid <= 1'b0;
      skv         <= 1'b0;
    end else if (noise.valid && noise.ready) begin
      if (skv) begin
        noise.noise_value <= skq;
        skv               <= 1'b0;
      end else begin
        noise.valid       <= dv[QB];
        noise.noise_value <= dq[QB];
      end
    end else if (!noise.valid) begin
      noise.valid       <= dv[QB];
      noise.noise_value <= dq[QB];
    end else if (dv[QB] && en) begin
      // output stalled: park the arriving result
      skv <= 1'b1;
      skq <= dq[QB];
    end
  end

  `ASSERT_CLK(a_skid_needs_out, clk, rst, !skv || noise.valid, "skid full with empty output")
  `ASSERT_NEXT(a_skid_holds, clk, rst, skv && !noise.ready, skv && noise.valid, "skid lost while stalled")
  `ASSERT_CLK(a_oct_range, clk, rst, n_oct >= OCT_W'(1) && n_oct <= OCT_W'(N), "octave count out of range")

endmodule

[bench/fractal_value_noise_2d_unit_tb.sv]
`timescale 1ns / 1ps

module fractal_value_noise_2d_unit_tb;
  import fvn_pkg::*;

  localparam int LATENCY = 2 + 5 * 8 + 16;
  localparam int FB = 16;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = CFG_FREQUENCY;
  logic [CFG_W-1:0] cfg_data = '0;

  fvn_coord_if coord ();
  fvn_noise_if noise ();

  fractal_value_noise_2d_unit dut (
    .clk(clk), .rst(rst), .coord(coord), .noise(noise),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Local copy of the registers
  logic [23:0] frequency_q;
  logic [3:0] octaves_q;
  logic [7:0] seed_q;

  logic [15:0] noise_q[$];
  int errors = 0;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic        known;
    logic [15:0] noise;
  } vector_t;

  function automatic longint unsigned lattice(int col, int row);
    int r;
    r = PERM[(row + seed_q) & 255];
    return longint'(PERM[(r + col) & 255]) << FB;
  endfunction

  function automatic longint unsigned smooth(longint unsigned t);
    longint unsigned t2;
    t2 = (t * t) >> FB;
    return (t2 * (3 * (64'd1 << FB) - 2 * t)) >> FB;
  endfunction

  function automatic longint unsigned mix(longint unsigned a, longint unsigned b,
                                          longint unsigned w);
    if (b >= a) return a + (((b - a) * w) >> FB);
    return a - (((a - b) * w) >> FB);
  endfunction

  function automatic logic [15:0] noise_at(logic [31:0] x, logic [31:0] y);
    longint unsigned mask, xa, ya, num, den, res, wx, wy, lo, hi;
    int n, xi, yi;
    mask = (64'd1 << 24) - 1;
    n = octaves_q;
    if (n < 1) n = 1;
    if (n > 8) n = 8;
    xa = ((64'(x) * frequency_q) >> 16) & mask;
    ya = ((64'(y) * frequency_q) >> 16) & mask;
    num = 0;
    for (int i = 0; i < n; i++) begin
      xi = (xa >> FB) & 255;
      yi = (ya >> FB) & 255;
      wx = smooth(xa & 16'hffff);
      wy = smooth(ya & 16'hffff);
      lo = mix(lattice(xi, yi), lattice(xi + 1, yi), wx);
      hi = mix(lattice(xi, yi + 1), lattice(xi + 1, yi + 1), wx);
      num += mix(lo, hi, wy) << (n - 1 - i);
      xa = (xa << 1) & mask;
      ya = (ya << 1) & mask;
    end
    den = ((64'd1 << n) - 1) << 24;
    res = (num << 16) / den;
    if (res > 16'hffff) res = 16'hffff;
    return res[15:0];
  endfunction

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [23:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_FREQUENCY: frequency_q = val;
      CFG_OCTAVES:   octaves_q = val[3:0];
      CFG_SEED:      seed_q = val[7:0];
      default: ;
    endcase
  endtask

  // Hold valid across back-to-back requests; drop it only for a gap
  task automatic send_request(logic [31:0] x, logic [31:0] y);
    int gap;
    gap = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      coord.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    coord.valid <= 1'b1;
    coord.x_coord <= x;
    coord.y_coord <= y;
    noise_q.push_back(noise_at(x, y));
    do @(posedge clk); while (!coord.ready);
  endtask

  task automatic drain();
    coord.valid <= 1'b0;
    while (noise_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Receiver: random stalls, compare against oldest prediction
  initial begin
    int stall;
    noise.ready = 1'b0;
    @(negedge rst);
    forever begin
      stall = $urandom_range(0, 9);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall > 0) begin
        noise.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      noise.ready <= 1'b1;
      do @(posedge clk); while (!noise.valid);
      if (noise_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time,
                 noise.noise_value);
        errors++;
      end else begin
        if (noise.noise_value !== noise_q[0]) begin
          $display("%0t: noise_value mismatch, expected %h, actual %h", $time,
                   noise_q[0], noise.noise_value);
          errors++;
        end
        void'(noise_q.pop_front());
      end
    end
  end

  initial begin
    vector_t table_v[$];
    vector_t v;
    logic [31:0] x, y;
    coord.valid = 1'b0;
    coord.x_coord = '0;
    coord.y_coord = '0;
    frequency_q = FREQUENCY_RESET;
    octaves_q = OCTAVES_RESET;
    seed_q = SEED_RESET;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Origin and edge coordinates at the reset settings, predicted
    table_v.push_back('{32'h0, 32'h0, 1'b0, 16'h0});
    table_v.push_back('{32'hffffffff, 32'hffffffff, 1'b0, 16'h0});
    table_v.push_back('{32'hffffffff, 32'h0, 1'b0, 16'h0});
    table_v.push_back('{32'h0, 32'hffffffff, 1'b0, 16'h0});
    table_v.push_back('{32'h00008000, 32'h00008000, 1'b0, 16'h0});
    table_v.push_back('{32'h00ff0000, 32'h00ff0000, 1'b0, 16'h0});
    table_v.push_back('{32'h80000000, 32'h7fffffff, 1'b0, 16'h0});
    table_v.push_back('{32'h0000ffff, 32'h00010000, 1'b0, 16'h0});
    table_v.push_back('{32'h55555555, 32'haaaaaaaa, 1'b0, 16'h0});
    // Reset frequency: send every row of the table
    foreach (table_v[i]) begin
      v = table_v[i];
      send_request(v.x, v.y);
    end
    drain();

    // Zero octave count is taken as one, and zero frequency pins the corner
    write_reg(CFG_FREQUENCY, 24'h0);
    write_reg(CFG_OCTAVES, 24'h0);
    write_reg(CFG_SEED, 24'h0);
    // one octave at cell 0 with seed 0: PERM[PERM[0]] = PERM[208] = 42
    table_v = {};
    table_v.push_back('{32'h12345678, 32'hffffffff, 1'b1, 16'((64'd42 << 16) / 256)});
    table_v.push_back('{32'hffffffff, 32'h0, 1'b1, 16'((64'd42 << 16) / 256)});
    foreach (table_v[i]) begin
      v = table_v[i];
      if (v.known && noise_at(v.x, v.y) !== v.noise) begin
        $display("%0t: table row %0d, expected %h, actual %h", $time, i, v.noise,
                 noise_at(v.x, v.y));
        errors++;
      end
      send_request(v.x, v.y);
    end
    drain();

    // Octave count above the maximum saturates; extreme frequency and seed
    write_reg(CFG_OCTAVES, 24'hf);
    write_reg(CFG_FREQUENCY, 24'hffffff);
    write_reg(CFG_SEED, 24'hff);
    write_reg(2'd3, 24'h123456);  // out of range, ignored
    send_request(32'hffffffff, 32'hffffffff);
    send_request(32'h0, 32'h0);
    send_request(32'h00018000, 32'hfffe0001);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      write_reg(CFG_FREQUENCY, (phase % 3 == 0) ? 24'h010000 : 24'($urandom()));
      write_reg(CFG_OCTAVES, (phase == 0) ? 24'd8 : (phase == 1) ? 24'd1
                : 24'($urandom_range(0, 15)));
      write_reg(CFG_SEED, 24'($urandom_range(0, 255)));
      for (int k = 0; k < 200; k++) begin
        x = $urandom();
        y = $urandom();
        if ($urandom_range(0, 3) == 0) x = x & 32'h00ffffff;
        if ($urandom_range(0, 3) == 0) y = y & 32'h00ffffff;
        send_request(x, y);
      end
      drain();
    end
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

endmodule

[sim.f]
+incdir+design
design/fvn_pkg.sv
design/fvn_coord_if.sv
design/fvn_noise_if.sv
design/fvn_octave_cell.sv
design/fvn_div_cell.sv
design/fractal_value_noise_2d_unit.sv
bench/fractal_value_noise_2d_unit_tb.sv
